/* hdl/assert_macros.svh */
// Assertion helpers, clocked on clock, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHECK_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/gct_pkg.sv */
package gct_pkg;

   localparam int CHANNELS  = 3;
   localparam int FRAC_BITS = 24;
   localparam int LAT       = 28;

   localparam logic REG_GAIN  = 1'b0;
   localparam logic REG_GAMMA = 1'b1;

   localparam logic [11:0] GAIN_RESET  = 12'd256;
   localparam logic [11:0] GAMMA_RESET = 12'd256;

   typedef logic [26:0] ltab_type [256];
   typedef logic [31:0] ftab_type [FRAC_BITS];

   function automatic logic [63:0] int_sqrt(input logic [63:0] a_in);
      logic [63:0] a;
      logic [63:0] root;
      logic [63:0] bitv;
      a    = a_in;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > a) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (a >= root + bitv) begin
            a    = a - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [27:0] log2_fix(input logic [7:0] x);
      logic [63:0] m;
      logic [27:0] res;
      int n;
      n = 0;
      for (int i = 1; i < 8; i++) begin
         if ((x >> i) != 8'd0) n = i;
      end
      res = 28'(n) << 24;
      m   = 64'(x) << (31 - n);
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 31;
         if (m[32]) begin
            res[23 - i] = 1'b1;
            m = m >> 1;
         end
      end
      return res;
   endfunction

   // log2(255) - log2(v), Q.24; entry 0 unused
   function automatic ltab_type build_ltab();
      ltab_type t;
      logic [27:0] a;
      a    = log2_fix(8'd255);
      t[0] = '0;
      for (int v = 1; v < 256; v++) t[v] = 27'(a - log2_fix(8'(v)));
      return t;
   endfunction

   // 2^-(2^-(k+1)) in Q1.31
   function automatic ftab_type build_fac();
      ftab_type t;
      t[0] = 32'(int_sqrt(64'd1 << 61));
      for (int k = 1; k < FRAC_BITS; k++) t[k] = 32'(int_sqrt(64'(t[k - 1]) << 31));
      return t;
   endfunction

   localparam ltab_type LOG_TBL = build_ltab();
   localparam ftab_type FAC_TBL = build_fac();

endpackage

/* hdl/gct_power.sv */
module gct_power (
   input  logic        clock,
   input  logic [7:0]  v_in,
   input  logic [11:0] gamma_in,
   output logic [31:0] p_out,
   output logic [6:0]  n_out,
   output logic        kill_out
);

   localparam int NF = gct_pkg::FRAC_BITS;

   logic [31:0] p_ff    [NF + 1];
   logic [23:0] f_ff    [NF + 1];
   logic [6:0]  n_ff    [NF + 1];
   logic        kill_ff [NF + 1];

   logic [38:0] e_prod;
   logic [26:0] l_val;

   always_comb begin
      l_val  = gct_pkg::LOG_TBL[v_in];
      e_prod = 39'(l_val) * 39'(gamma_in);
   end

   always_ff @(posedge clock) begin
      p_ff[0]    <= 32'd1 << 31;
      f_ff[0]    <= e_prod[31:8];
      n_ff[0]    <= e_prod[38:32];
      kill_ff[0] <= (v_in == 8'd0) && (gamma_in != 12'd0);
   end

   // one factor per stage, applied when its fraction bit is set
   for (genvar k = 0; k < NF; k++) begin : g_step
      logic [63:0] prod;
      assign prod = 64'(p_ff[k]) * 64'(gct_pkg::FAC_TBL[k]);
      always_ff @(posedge clock) begin
         p_ff[k + 1]    <= f_ff[k][NF - 1 - k] ? prod[62:31] : p_ff[k];
         f_ff[k + 1]    <= f_ff[k];
         n_ff[k + 1]    <= n_ff[k];
         kill_ff[k + 1] <= kill_ff[k];
      end
   end

   assign p_out    = p_ff[NF];
   assign n_out    = n_ff[NF];
   assign kill_out = kill_ff[NF];

endmodule

/* hdl/gct_round.sv */
module gct_round (
   input  logic        clock,
   input  logic [11:0] gain_in,
   input  logic [31:0] p_in,
   input  logic [6:0]  n_in,
   input  logic        kill_in,
   output logic [7:0]  value_out
);

   logic [51:0] x_ff;
   logic [6:0]  n_ff;
   logic        kill_ff;
   logic [7:0]  value_ff;

   logic [19:0] g255;
   logic [51:0] x_in;
   logic [5:0]  s;
   logic [51:0] margin;
   logic [63:0] sum;
   logic [63:0] q;
   logic [7:0]  value_in;

   always_comb begin
      g255 = (20'(gain_in) << 8) - 20'(gain_in);
      x_in = 52'(g255) * 52'(p_in);
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      n_ff    <= n_in;
      kill_ff <= kill_in;
   end

   // ceil(x / 2^s - 2^-12), s = 39 + n, saturated
   always_comb begin
      s        = 6'(7'd39 + n_ff);
      margin   = 52'd1 << (s - 6'd12);
      sum      = 64'(x_ff - margin) + ((64'd1 << s) - 64'd1);
      q        = sum >> s;
      value_in = (q > 64'd255) ? 8'd255 : q[7:0];
      if (kill_ff || (n_ff >= 7'd25) || (x_ff <= margin)) value_in = 8'd0;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

/* hdl/gamma_correction_transform_core.sv */
// channel  ports                               handshake
// req      req_blue/green/red_in               start & !busy
// rsp      rsp_blue/green/red_out              rsp_valid strobe, one cycle
// csr      csr_index, csr_wdata                csr_write
//
// One item per cycle; results pass the input and log registers, the
// 24-stage exp2 factor chain (one multiply per stage), then rounding.
// busy is always low. Synchronous reset clears valid bits and loads
// gain/gamma defaults. No stalls: results are strobed once.
`include "assert_macros.svh"

module gamma_correction_transform_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_blue_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_red_in,
   output logic        rsp_valid,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_red_out,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int NCH = gct_pkg::CHANNELS;
   localparam int LAT = gct_pkg::LAT;

   logic [11:0] gain_ff;
   logic [11:0] gamma_ff;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;
   logic [7:0] pix_ff [NCH];
   logic [7:0] pix_in [NCH];
   logic [7:0] res    [NCH];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= gct_pkg::GAIN_RESET;
         gamma_ff <= gct_pkg::GAMMA_RESET;
      end else if (csr_write) begin
         case (csr_index)
            gct_pkg::REG_GAIN:  gain_ff  <= csr_wdata;
            gct_pkg::REG_GAMMA: gamma_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign vld_in = {vld_ff[LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign pix_in[0] = req_blue_in;
   assign pix_in[1] = req_green_in;
   assign pix_in[2] = req_red_in;

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   for (genvar c = 0; c < NCH; c++) begin : g_ch
      logic [31:0] p;
      logic [6:0]  n;
      logic        kill;

      gct_power u_power (
         .clock    (clock),
         .v_in     (pix_ff[c]),
         .gamma_in (gamma_ff),
         .p_out    (p),
         .n_out    (n),
         .kill_out (kill)
      );

      gct_round u_round (
         .clock     (clock),
         .gain_in   (gain_ff),
         .p_in      (p),
         .n_in      (n),
         .kill_in   (kill),
         .value_out (res[c])
      );
   end

   assign rsp_valid     = vld_ff[LAT-1];
   assign rsp_blue_out  = res[0];
   assign rsp_green_out = res[1];
   assign rsp_red_out   = res[2];

   `CHECK_IMPLY(a_out_from_in, rsp_valid, $past(start, LAT), "result without item")
   `CHECK_NEXT(a_vld_move, vld_ff[0], vld_ff[1], "valid bit lost in pipe")
   `CHECK_IMPLY(a_not_busy, start, !busy, "busy raised")

endmodule

/* bench/tb.sv */
module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_blue_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_red_in = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_blue_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_red_out;
   logic        csr_write = 1'b0;
   logic        csr_index = gct_pkg::REG_GAIN;
   logic [11:0] csr_wdata = '0;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   int errors = 0;
   int pixels_sent = 0;
   int pixels_checked = 0;

   gamma_correction_transform_core DUT (.*);

   always #1 clock = ~clock;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d (pixel %0d)", what, got, want, pixels_checked);
      errors++;
   endtask

   // fixed-point power law: log2 / multiply / exp2
   class gamma_board;
      logic [11:0] gain_q = gct_pkg::GAIN_RESET;
      logic [11:0] gamma_q = gct_pkg::GAMMA_RESET;
      logic [63:0] exp_fac [24];
      pixel_type   pending [$];

      function new();
         exp_fac[0] = isqrt(64'd1 << 61);
         for (int k = 1; k < 24; k++) exp_fac[k] = isqrt(exp_fac[k - 1] << 31);
      endfunction

      function logic [63:0] isqrt(input logic [63:0] a_in);
         logic [63:0] a, r, b;
         a = a_in;
         r = 0;
         b = 64'd1 << 62;
         while (b > a) b >>= 2;
         while (b != 0) begin
            if (a >= r + b) begin
               a -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function logic [63:0] log2_q24(input logic [7:0] x);
         logic [63:0] m, res;
         int n;
         n = 0;
         for (int i = 1; i < 8; i++) if ((x >> i) != 0) n = i;
         res = 64'(n) << 24;
         m = 64'(x) << (31 - n);
         for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
               res[23 - i] = 1'b1;
               m >>= 1;
            end
         end
         return res;
      endfunction

      function logic [7:0] correct(input logic [7:0] v);
         logic [63:0] p, x, q, l, e, a, b, ni, margin;
         int n, s;
         if (v == 0) begin
            if (gamma_q != 0) return 8'd0;
            p = 64'd1 << 31;
            n = 0;
         end else begin
            a = log2_q24(8'd255);
            b = log2_q24(v);
            l = (a > b) ? a - b : 0;
            e = (l * gamma_q) >> 8;
            ni = e >> 24;
            n = (ni > 64) ? 64 : int'(ni);
            p = 64'd1 << 31;
            for (int k = 0; k < 24; k++) if (e[23 - k]) p = (p * exp_fac[k]) >> 31;
         end
         x = 64'(gain_q) * 255 * p;
         s = 39 + n;
         if (s >= 64) return 8'd0;
         margin = 64'd1 << (s - 12);
         if (x <= margin) return 8'd0;
         x -= margin;
         q = (x + ((64'd1 << s) - 1)) >> s;
         return (q > 255) ? 8'd255 : q[7:0];
      endfunction

      function void note_pixel(input pixel_type px);
         pixel_type o;
         o.blue = correct(px.blue);
         o.green = correct(px.green);
         o.red = correct(px.red);
         pending.push_back(o);
      endfunction

      task check_pixel(input pixel_type got);
         pixel_type w;
         if (pending.size() == 0) begin
            report("unexpected item", 1, 0);
            return;
         end
         w = pending.pop_front();
         if (got.blue !== w.blue) report("blue", got.blue, w.blue);
         if (got.green !== w.green) report("green", got.green, w.green);
         if (got.red !== w.red) report("red", got.red, w.red);
         pixels_checked++;
      endtask
   endclass

   gamma_board board = new();

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_pixel({rsp_blue_out, rsp_green_out, rsp_red_out});
   end

   task automatic write_reg(input logic idx, input logic [11:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == gct_pkg::REG_GAIN) board.gain_q = val;
      else board.gamma_q = val;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (gct_pkg::LAT + 4) @(posedge clock);
   endtask

   task automatic send_pixel(input pixel_type px, input bit gaps);
      if (gaps && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      start <= 1'b1;
      req_blue_in <= px.blue;
      req_green_in <= px.green;
      req_red_in <= px.red;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_pixel(px);
      pixels_sent++;
   endtask

   task automatic idle_in();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(1, 8));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [11:0] pick_q48();
      case ($urandom_range(0, 6))
         0: return 12'd0;
         1: return 12'd4095;
         2: return 12'd256;
         3: return 12'($urandom_range(1, 64));
         default: return 12'($urandom);
      endcase
   endfunction

   initial begin
      pixel_type px;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values, then directed edges
      send_pixel('{8'd0, 8'd255, 8'd128}, 0);
      send_pixel('{8'd1, 8'd2, 8'd254}, 0);
      idle_in();
      drain();
      write_reg(gct_pkg::REG_GAMMA, 12'd0);
      write_reg(gct_pkg::REG_GAIN, 12'd4095);
      send_pixel('{8'd0, 8'd255, 8'd1}, 0);
      idle_in();
      drain();
      write_reg(gct_pkg::REG_GAIN, 12'd0);
      write_reg(gct_pkg::REG_GAMMA, 12'd4095);
      send_pixel('{8'd0, 8'd255, 8'd1}, 0);
      idle_in();
      drain();
      write_reg(gct_pkg::REG_GAIN, 12'd4095);
      send_pixel('{8'd1, 8'd3, 8'd255}, 0);
      send_pixel('{8'd170, 8'd85, 8'd200}, 0);
      idle_in();
      drain();
      write_reg(gct_pkg::REG_GAIN, 12'd256);
      write_reg(gct_pkg::REG_GAMMA, 12'd1);
      send_pixel('{8'd1, 8'd0, 8'd254}, 0);
      send_pixel('{8'hAA, 8'h55, 8'hFF}, 0);
      idle_in();
      drain();

      for (int ph = 0; ph < 11; ph++) begin
         write_reg(gct_pkg::REG_GAIN, pick_q48());
         write_reg(gct_pkg::REG_GAMMA, pick_q48());
         for (int i = 0; i < 100; i++) begin
            px.blue = pick_level();
            px.green = pick_level();
            px.red = pick_level();
            send_pixel(px, ph < 9);
         end
         idle_in();
         drain();
      end

      $display("sent %0d pixels, checked %0d", pixels_sent, pixels_checked);
      $display("covered directed and random gain/gamma settings, zero and full levels");
      if (errors == 0 && board.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("FAIL");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+hdl
hdl/gct_pkg.sv
hdl/gct_power.sv
hdl/gct_round.sv
hdl/gamma_correction_transform_core.sv
bench/tb.sv
